FILE: src/ifd_pkg.sv
package ifd_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W      = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] STUFF_MASK = 8'h20;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        REG_FLAG  = 3'd0,
        REG_ESC   = 3'd1,
        REG_ADDR  = 3'd2,
        REG_CTRL0 = 3'd3,
        REG_CTRL1 = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_DATA,
        PH_ESC
    } t_phase;

    typedef enum logic [1:0] {
        V_NEW  = 2'd0,
        V_DUP  = 2'd1,
        V_ERR  = 2'd2,
        V_LONG = 2'd3
    } t_verdict;

    // one line byte with its compare results against the configured codes
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_flag;
        logic       is_esc;
        logic       is_addr;
        logic       is_ctrl0;
        logic       is_ctrl1;
        logic       is_bcc0;
        logic       is_bcc1;
    } t_token;

    typedef struct packed {
        logic             out_kind;
        logic [7:0]       data_byte;
        t_verdict         verdict;
        logic             rx_seq;
        logic [LEN_W-1:0] payload_len;
        logic             next_seq;
    } t_result;

endpackage

FILE: src/ifd_front.sv
module ifd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ifd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic [7:0]                  i_rx_byte,
    output ifd_pkg::t_token             o_token
);
    import ifd_pkg::*;

    logic [7:0] r_flag, r_esc, r_addr, r_ctrl0, r_ctrl1;
    t_reg_idx   reg_idx;
    logic       wr_en;
    logic [7:0] rd_val;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= 8'h7E;
            r_esc   <= 8'h7D;
            r_addr  <= 8'h03;
            r_ctrl0 <= 8'h00;
            r_ctrl1 <= 8'h40;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FLAG:  r_flag  <= pwdata[7:0];
                REG_ESC:   r_esc   <= pwdata[7:0];
                REG_ADDR:  r_addr  <= pwdata[7:0];
                REG_CTRL0: r_ctrl0 <= pwdata[7:0];
                REG_CTRL1: r_ctrl1 <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FLAG:  rd_val = r_flag;
            REG_ESC:   rd_val = r_esc;
            REG_ADDR:  rd_val = r_addr;
            REG_CTRL0: rd_val = r_ctrl0;
            REG_CTRL1: rd_val = r_ctrl1;
            default:   rd_val = 8'h00;
        endcase
    end

    assign prdata = {24'h000000, rd_val};

    // BCC1 is checked against both possible control codes here; the back end
    // picks the one that matches the sequence it latched.
    always_comb begin
        o_token.rx_byte  = i_rx_byte;
        o_token.is_flag  = (i_rx_byte == r_flag);
        o_token.is_esc   = (i_rx_byte == r_esc);
        o_token.is_addr  = (i_rx_byte == r_addr);
        o_token.is_ctrl0 = (i_rx_byte == r_ctrl0);
        o_token.is_ctrl1 = (i_rx_byte == r_ctrl1);
        o_token.is_bcc0  = (i_rx_byte == (r_addr ^ r_ctrl0));
        o_token.is_bcc1  = (i_rx_byte == (r_addr ^ r_ctrl1));
    end

endmodule

FILE: src/ifd_queue.sv
module ifd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ifd_pkg::t_token  i_data,
    input  logic             i_pop,
    output ifd_pkg::t_token  o_head,
    output logic             o_head_valid,
    output logic             o_full
);
    import ifd_pkg::*;

    t_token            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;
    assign o_head       = mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/ifd_back.sv
module ifd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ifd_pkg::t_token  i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output ifd_pkg::t_result o_result
);
    import ifd_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    t_phase           r_phase, n_phase;
    logic             r_exp_seq, n_exp_seq;
    logic             r_frame_seq, n_frame_seq;
    logic [7:0]       r_held, n_held;
    logic             r_held_valid, n_held_valid;
    logic [7:0]       r_xor, n_xor;
    logic [LEN_W-1:0] r_count, n_count;
    logic             r_overflow, n_overflow;
    logic             r_out_valid;
    t_result          r_out;

    logic             fire;
    logic             emit;
    t_result          res;
    logic [7:0]       pay_byte;
    logic             take;
    logic             close;
    logic             aborted;
    t_verdict         verd;

    assign fire        = i_head_valid && (!r_out_valid || !i_out_stall);
    assign o_pop       = fire;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_exp_seq    <= 1'b0;
            r_frame_seq  <= 1'b0;
            r_held       <= 8'h00;
            r_held_valid <= 1'b0;
            r_xor        <= 8'h00;
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (fire) begin
            r_phase      <= n_phase;
            r_exp_seq    <= n_exp_seq;
            r_frame_seq  <= n_frame_seq;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_xor        <= n_xor;
            r_count      <= n_count;
            r_overflow   <= n_overflow;
            r_out_valid  <= emit;
        end else if (!i_out_stall) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= res;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_exp_seq    = r_exp_seq;
        n_frame_seq  = r_frame_seq;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_xor        = r_xor;
        n_count      = r_count;
        n_overflow   = r_overflow;
        take         = 1'b0;
        close        = 1'b0;
        aborted      = 1'b0;
        pay_byte     = i_head.rx_byte;
        emit         = 1'b0;
        verd         = V_NEW;

        unique case (r_phase)
            PH_HUNT: begin
                if (i_head.is_flag) begin
                    n_phase = PH_FLAG;
                end
            end
            PH_FLAG: begin
                priority if (i_head.is_addr) begin
                    n_phase = PH_ADDR;
                end else if (!i_head.is_flag) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_phase = PH_FLAG;
                end
            end
            PH_ADDR: begin
                priority if (i_head.is_ctrl0) begin
                    n_frame_seq = 1'b0;
                    n_phase     = PH_CTRL;
                end else if (i_head.is_ctrl1) begin
                    n_frame_seq = 1'b1;
                    n_phase     = PH_CTRL;
                end else if (i_head.is_flag) begin
                    n_phase = PH_FLAG;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CTRL: begin
                priority if (r_frame_seq ? i_head.is_bcc1 : i_head.is_bcc0) begin
                    n_held       = 8'h00;
                    n_held_valid = 1'b0;
                    n_xor        = 8'h00;
                    n_count      = '0;
                    n_overflow   = 1'b0;
                    n_phase      = PH_DATA;
                end else if (i_head.is_flag) begin
                    n_phase = PH_FLAG;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                priority if (i_head.is_flag) begin
                    close = 1'b1;
                end else if (i_head.is_esc) begin
                    n_phase = PH_ESC;
                end else begin
                    take = 1'b1;
                end
            end
            PH_ESC: begin
                if (i_head.is_flag) begin
                    close   = 1'b1;
                    aborted = 1'b1;
                end else begin
                    n_phase  = PH_DATA;
                    pay_byte = i_head.rx_byte ^ STUFF_MASK;
                    take     = 1'b1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        // payload byte enters the check; the previous one goes out if room
        if (take) begin
            n_xor = r_xor ^ pay_byte;
            if (r_held_valid) begin
                if (r_count < MAX_LEN) begin
                    n_count = r_count + 1'b1;
                    emit    = 1'b1;
                end else begin
                    n_overflow = 1'b1;
                end
            end
            n_held       = pay_byte;
            n_held_valid = 1'b1;
        end

        if (close) begin
            priority if (r_overflow) begin
                verd = V_LONG;
            end else if (aborted || !r_held_valid || r_xor != 8'h00) begin
                verd = V_ERR;
            end else if (r_frame_seq == r_exp_seq) begin
                verd      = V_NEW;
                n_exp_seq = ~r_exp_seq;
            end else begin
                verd = V_DUP;
            end
            n_phase = PH_FLAG;
            emit    = 1'b1;
        end

        res.out_kind    = close ? KIND_VERDICT : KIND_DATA;
        res.data_byte   = close ? 8'h00 : r_held;
        res.verdict     = close ? verd : V_NEW;
        res.rx_seq      = n_frame_seq;
        res.payload_len = n_count;
        res.next_seq    = n_exp_seq;
    end

endmodule

FILE: src/info_frame_deframer.sv
// Byte-stuffed information frame receiver. One line byte is taken per cycle
// with no gaps as long as the result side keeps up: the front end compares each
// byte with the configured flag, escape, address, control and BCC1 codes, a
// four-entry queue carries the classified bytes, and the back end runs the
// frame state machine and registers at most one result per byte. Payload
// bytes come out one byte late (the last byte before the closing flag is
// BCC2 and is never passed on), and each frame ends with a verdict transfer:
// accepted new, duplicate, check error or too long. Input bytes are
// registered in the queue and the back end registers each result; stalls on
// the result side fill the queue and then raise o_in_stall. Write the
// registers only while no bytes are in flight.
module info_frame_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ifd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_out_kind,
    output logic [7:0]                  o_data_byte,
    output logic [1:0]                  o_verdict,
    output logic                        o_rx_seq,
    output logic [ifd_pkg::LEN_W-1:0]   o_payload_len,
    output logic                        o_next_seq
);
    import ifd_pkg::*;

    t_token  token;
    t_token  head;
    logic    head_valid;
    logic    full;
    logic    pop;
    t_result result;

    ifd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_rx_byte (i_rx_byte),
        .o_token   (token)
    );

    ifd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_in_valid),
        .i_data       (token),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (full)
    );

    assign o_in_stall = full;

    ifd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_result     (result)
    );

    assign o_out_kind    = result.out_kind;
    assign o_data_byte   = result.data_byte;
    assign o_verdict     = result.verdict;
    assign o_rx_seq      = result.rx_seq;
    assign o_payload_len = result.payload_len;
    assign o_next_seq    = result.next_seq;

endmodule
